### src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### src/dgff_pkg.sv
package dgff_pkg;
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] CODE_FREE = 3'd0;
    localparam logic [2:0] CODE_WALL = 3'd1;
    localparam logic [2:0] CODE_FWD  = 3'd2;
    localparam logic [2:0] CODE_BWD  = 3'd3;
    localparam logic [2:0] CODE_BOTH = 3'd4;

    localparam logic [2:0] LIM_C_LE_END   = 3'd0;
    localparam logic [2:0] LIM_C_GE_START = 3'd1;
    localparam logic [2:0] LIM_R_GE_END   = 3'd2;
    localparam logic [2:0] LIM_R_LE_START = 3'd3;
    localparam logic [2:0] LIM_C_GT_START = 3'd4;

    localparam logic [2:0] REG_ROI_RL = 3'd0;
    localparam logic [2:0] REG_ROI_RH = 3'd1;
    localparam logic [2:0] REG_ROI_CL = 3'd2;
    localparam logic [2:0] REG_ROI_CH = 3'd3;
    localparam logic [2:0] REG_SR     = 3'd4;
    localparam logic [2:0] REG_SC     = 3'd5;
    localparam logic [2:0] REG_ER     = 3'd6;
    localparam logic [2:0] REG_EC     = 3'd7;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] row;
        logic [5:0] col;
        logic [2:0] cell_code;
        logic [3:0] fill_pattern;
    } item_t;

    typedef struct packed {
        logic [2:0] read_code;
        logic       done_res;
    } result_t;

    typedef struct packed {
        logic [5:0] roi_rl;
        logic [5:0] roi_rh;
        logic [5:0] roi_cl;
        logic [5:0] roi_ch;
        logic [5:0] sr;
        logic [5:0] sc;
        logic [5:0] er;
        logic [5:0] ec;
    } cfg_t;

    // one neighbour offset, range -2..2
    typedef struct packed {
        logic signed [2:0] dr;
        logic signed [2:0] dc;
    } ofs_t;

    typedef struct packed {
        logic              backward;
        logic [2:0]        limit;
        logic              has_pair;
        logic signed [2:0] pair_dr;
        logic signed [2:0] pair_dc;
        logic              margin;
        logic [1:0]        count;
        ofs_t [2:0]        rising;
        ofs_t [2:0]        other;
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_RD,
        ST_PAIR,
        ST_CHECK,
        ST_PUSH,
        ST_DONE
    } state_t;

    function automatic ofs_t mk(input int r, input int c);
        ofs_t o;
        o.dr = 3'(r);
        o.dc = 3'(c);
        return o;
    endfunction

    function automatic kind_t kind_of(input logic [3:0] p);
        kind_t k;
        k = '0;
        case (p)
            4'd0: begin k.limit = LIM_C_LE_END; k.count = 2'd3;
                k.rising = {mk(1,1), mk(-1,1), mk(0,1)}; k.other = k.rising; end
            4'd1: begin k.backward = 1'b1; k.limit = LIM_C_GE_START; k.count = 2'd3;
                k.rising = {mk(1,-1), mk(-1,-1), mk(0,-1)}; k.other = k.rising; end
            4'd2: begin k.limit = LIM_R_GE_END; k.count = 2'd3;
                k.rising = {mk(-1,1), mk(-1,-1), mk(-1,0)}; k.other = k.rising; end
            4'd3: begin k.backward = 1'b1; k.limit = LIM_R_LE_START; k.count = 2'd3;
                k.rising = {mk(1,1), mk(1,-1), mk(1,0)}; k.other = k.rising; end
            4'd4: begin k.limit = LIM_C_LE_END; k.count = 2'd3;
                k.rising = {mk(-1,0), mk(-1,1), mk(0,1)};
                k.other = {mk(1,0), mk(1,1), mk(0,1)}; end
            4'd5: begin k.backward = 1'b1; k.limit = LIM_C_GE_START; k.count = 2'd3;
                k.rising = {mk(1,0), mk(1,-1), mk(0,-1)};
                k.other = {mk(-1,0), mk(-1,-1), mk(0,-1)}; end
            4'd6: begin k.limit = LIM_C_LE_END; k.has_pair = 1'b1; k.pair_dc = 3'sd1;
                k.count = 2'd3; k.rising = {mk(1,2), mk(-1,2), mk(0,2)};
                k.other = k.rising; end
            4'd7: begin k.backward = 1'b1; k.limit = LIM_C_GE_START; k.has_pair = 1'b1;
                k.pair_dc = -3'sd1; k.count = 2'd3;
                k.rising = {mk(1,-2), mk(-1,-2), mk(0,-2)}; k.other = k.rising; end
            4'd8: begin k.limit = LIM_R_GE_END; k.has_pair = 1'b1; k.pair_dr = -3'sd1;
                k.count = 2'd3; k.rising = {mk(-2,-1), mk(-2,1), mk(-2,0)};
                k.other = k.rising; end
            4'd9: begin k.backward = 1'b1; k.limit = LIM_R_LE_START; k.has_pair = 1'b1;
                k.pair_dr = 3'sd1; k.count = 2'd3;
                k.rising = {mk(2,1), mk(2,-1), mk(2,0)}; k.other = k.rising; end
            4'd10: begin k.limit = LIM_C_LE_END; k.margin = 1'b1; k.count = 2'd3;
                k.rising = {mk(-1,2), mk(-2,1), mk(-1,1)};
                k.other = {mk(1,2), mk(2,1), mk(1,1)}; end
            4'd11: begin k.backward = 1'b1; k.limit = LIM_C_GT_START; k.margin = 1'b1;
                k.count = 2'd3; k.rising = {mk(2,-1), mk(1,-2), mk(1,-1)};
                k.other = {mk(-2,-1), mk(-1,-2), mk(-1,-1)}; end
            4'd12: begin k.limit = LIM_C_LE_END; k.count = 2'd2;
                k.rising = {mk(0,0), mk(0,1), mk(-1,1)};
                k.other = {mk(0,0), mk(0,1), mk(1,1)}; end
            4'd13: begin k.backward = 1'b1; k.limit = LIM_C_GE_START; k.count = 2'd2;
                k.rising = {mk(0,0), mk(0,-1), mk(1,-1)};
                k.other = {mk(0,0), mk(0,-1), mk(-1,-1)}; end
            4'd14: begin k.limit = LIM_C_LE_END; k.count = 2'd2;
                k.rising = {mk(0,0), mk(-1,1), mk(-1,0)};
                k.other = {mk(0,0), mk(1,1), mk(1,0)}; end
            default: begin k.backward = 1'b1; k.limit = LIM_C_GE_START; k.count = 2'd2;
                k.rising = {mk(0,0), mk(1,-1), mk(1,0)};
                k.other = {mk(0,0), mk(-1,-1), mk(-1,0)}; end
        endcase
        return k;
    endfunction
endpackage

### src/directional_grid_flood_fill_unit.sv
// Directional grid flood fill. A write or read passes from idle to the done
// state, where the registered read data of the grid memory is taken, and then
// gives the done strobe. A fill walks the grid depth first: each popped cell
// goes through pop, cell read, partner read for two-cell patterns and check,
// and then a push step per pushed neighbour, so its length follows the number
// of cells visited. busy is high while an item is at work, and the strobe is
// high for a single cycle and cannot be stalled. After reset a clearing pass
// writes every grid cell free, one a cycle, with busy high.
module directional_grid_flood_fill_unit #(
    parameter int GRID_ROWS   = 64,
    parameter int GRID_COLS   = 64,
    parameter int STACK_DEPTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dgff_pkg::item_t  item,
    output logic             strobe,
    output dgff_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [5:0]       cfg_data
);
    import dgff_pkg::*;
    `include "assert_macros.svh"

    localparam int RW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int GAW  = $clog2(GRID_ROWS * GRID_COLS);
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int SPW  = SAW + 1;
    // signed coordinate wide enough for seeds and offsets
    localparam int XW   = 12;

    typedef logic signed [XW-1:0] crd_t;

    cfg_t cfg_reg;
    state_t state_reg, state_next;
    logic [GAW:0] clr_reg;
    logic clr_done;
    kind_t kind_reg;
    logic [2:0] own_w, opp_w;
    logic rising_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    crd_t cr_reg, cc_reg, cr_next, cc_next;
    logic [2:0] v_reg, v_next;
    logic [2:0] nv_reg, nv_next;
    logic [1:0] pi_reg, pi_next;
    logic in_main_reg, in_main_next;
    item_t it_reg;
    logic strobe_reg, strobe_next;
    result_t res_reg, res_next;

    // grid and stack memory signals
    logic g_we;
    logic [GAW-1:0] g_waddr, g_raddr;
    logic [2:0] g_wdata, g_rdata;
    logic s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [2*XW-1:0] s_wdata, s_rdata;

    function automatic logic inside_grid(input crd_t r, input crd_t c);
        return r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS;
    endfunction

    function automatic logic [GAW-1:0] addr_of(input crd_t r, input crd_t c);
        logic [RW-1:0] rr;
        logic [CW-1:0] cc;
        rr = r[RW-1:0];
        cc = c[CW-1:0];
        return GAW'(rr * GRID_COLS + cc);
    endfunction

    function automatic logic blocks(input logic [2:0] v, input logic [2:0] own);
        return v == CODE_WALL || v == own || v == CODE_BOTH;
    endfunction

    dgff_grid_mem #(.AW(GAW)) u_grid (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    dgff_stack_mem #(.AW(SAW), .DW(2*XW)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    assign own_w = kind_reg.backward ? CODE_BWD : CODE_FWD;
    assign opp_w = kind_reg.backward ? CODE_FWD : CODE_BWD;
    assign clr_done = (clr_reg == (GAW+1)'(CELLS));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{6'd0, 6'd63, 6'd0, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROI_RL: cfg_reg.roi_rl <= cfg_data;
                REG_ROI_RH: cfg_reg.roi_rh <= cfg_data;
                REG_ROI_CL: cfg_reg.roi_cl <= cfg_data;
                REG_ROI_CH: cfg_reg.roi_ch <= cfg_data;
                REG_SR:     cfg_reg.sr <= cfg_data;
                REG_SC:     cfg_reg.sc <= cfg_data;
                REG_ER:     cfg_reg.er <= cfg_data;
                REG_EC:     cfg_reg.ec <= cfg_data;
                default:    cfg_reg.ec <= cfg_reg.ec;
            endcase
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (!clr_done)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sp_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cr_reg      <= cr_next;
        cc_reg      <= cc_next;
        v_reg       <= v_next;
        nv_reg      <= nv_next;
        pi_reg      <= pi_next;
        in_main_reg <= in_main_next;
        res_reg     <= res_next;
        if (start && !busy)
        begin
            it_reg     <= item;
            kind_reg   <= kind_of(item.fill_pattern);
            rising_reg <= cfg_reg.sr > cfg_reg.er;
        end
    end

    // walk sequencer
    always_comb
    begin
        crd_t pr, pc, m, nr, nc;
        logic pass, lim;
        ofs_t o;
        state_next   = state_reg;
        sp_next      = sp_reg;
        cr_next      = cr_reg;
        cc_next      = cc_reg;
        v_next       = v_reg;
        nv_next      = nv_reg;
        pi_next      = pi_reg;
        in_main_next = in_main_reg;
        strobe_next  = 1'b0;
        res_next     = res_reg;
        g_we    = 1'b0;
        g_waddr = addr_of(cr_reg, cc_reg);
        g_wdata = nv_reg;
        g_raddr = addr_of(cr_reg, cc_reg);
        s_we    = 1'b0;
        s_waddr = sp_reg[SAW-1:0];
        s_wdata = '0;
        s_raddr = SAW'(sp_reg - 1'b1);
        pr = cr_reg + crd_t'(kind_reg.pair_dr);
        pc = cc_reg + crd_t'(kind_reg.pair_dc);
        m  = crd_t'(kind_reg.margin);
        o  = rising_reg ? kind_reg.rising[pi_reg] : kind_reg.other[pi_reg];
        nr = cr_reg + crd_t'(o.dr);
        nc = cc_reg + crd_t'(o.dc);
        pass = 1'b0;
        lim  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!clr_done)
                begin
                    g_we    = 1'b1;
                    g_waddr = clr_reg[GAW-1:0];
                    g_wdata = CODE_FREE;
                end
                else if (start)
                begin
                    cr_next = crd_t'(item.row);
                    cc_next = crd_t'(item.col);
                    g_raddr = addr_of(crd_t'(item.row), crd_t'(item.col));
                    case (item.operation)
                        OP_WRITE:
                        begin
                            if (inside_grid(crd_t'(item.row), crd_t'(item.col)))
                            begin
                                g_we    = 1'b1;
                                g_waddr = addr_of(crd_t'(item.row), crd_t'(item.col));
                                g_wdata = (item.cell_code > CODE_BOTH) ? CODE_FREE
                                                                     : item.cell_code;
                            end
                            state_next = ST_DONE;
                        end
                        OP_FILL:
                        begin
                            // seed is the only pending cell
                            s_we       = 1'b1;
                            s_waddr    = '0;
                            s_wdata    = {crd_t'(item.row), crd_t'(item.col)};
                            sp_next    = SPW'(1);
                            state_next = ST_POP;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                // stack data valid: read main cell
                cr_next = crd_t'(signed'(s_rdata[2*XW-1:XW]));
                cc_next = crd_t'(signed'(s_rdata[XW-1:0]));
                in_main_next = inside_grid(cr_next, cc_next);
                g_raddr = addr_of(cr_next, cc_next);
                state_next = kind_reg.has_pair ? ST_PAIR : ST_CHECK;
            end
            ST_PAIR:
            begin
                v_next  = in_main_reg ? g_rdata : CODE_WALL;
                g_raddr = addr_of(pr, pc);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                logic [2:0] v, pv;
                v  = kind_reg.has_pair ? v_reg : (in_main_reg ? g_rdata : CODE_WALL);
                pv = inside_grid(pr, pc) ? g_rdata : CODE_WALL;
                pass = !blocks(v, own_w) && !(kind_reg.has_pair && blocks(pv, own_w));
                if (cr_reg <= crd_t'(cfg_reg.roi_rl) + m || cr_reg >= crd_t'(cfg_reg.roi_rh) - m
                    || cc_reg <= crd_t'(cfg_reg.roi_cl) + m
                    || cc_reg >= crd_t'(cfg_reg.roi_ch) - m)
                begin
                    pass = 1'b0;
                end
                case (kind_reg.limit)
                    LIM_C_LE_END:   lim = cc_reg > crd_t'(cfg_reg.ec);
                    LIM_C_GE_START: lim = cc_reg < crd_t'(cfg_reg.sc);
                    LIM_R_GE_END:   lim = cr_reg < crd_t'(cfg_reg.er);
                    LIM_R_LE_START: lim = cr_reg > crd_t'(cfg_reg.sr);
                    default:        lim = cc_reg <= crd_t'(cfg_reg.sc);
                endcase
                if (pass && !lim)
                begin
                    nv_next = (v == opp_w) ? CODE_BOTH : own_w;
                    g_we    = 1'b1;
                    g_waddr = addr_of(cr_reg, cc_reg);
                    g_wdata = nv_next;
                    pi_next = kind_reg.count - 1'b1;
                    state_next = ST_PUSH;
                    v_next  = kind_reg.has_pair ? 3'd7 : 3'd0;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_PUSH:
            begin
                // partner write shares the first push cycle slot
                if (v_reg == 3'd7)
                begin
                    g_we    = inside_grid(pr, pc);
                    g_waddr = addr_of(pr, pc);
                    g_wdata = nv_reg;
                    v_next  = 3'd0;
                end
                if (sp_reg < SPW'(STACK_DEPTH))
                begin
                    s_we    = 1'b1;
                    s_waddr = sp_reg[SAW-1:0];
                    s_wdata = {nr, nc};
                    sp_next = sp_reg + 1'b1;
                end
                pi_next = pi_reg - 1'b1;
                if (pi_reg == 2'd0)
                begin
                    state_next = ST_POP;
                end
            end
            ST_DONE:
            begin
                strobe_next = 1'b1;
                res_next.done_res = (it_reg.operation != OP_NONE);
                res_next.read_code = (it_reg.operation == OP_READ && inside_grid(cr_reg, cc_reg))
                                     ? g_rdata : CODE_FREE;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy   = (state_reg != ST_IDLE) || !clr_done;
    assign strobe = strobe_reg;
    assign result = res_reg;

    `ASSERT_IMPL(a_no_start_busy_strobe, clk, rst_n, strobe_reg, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_sp_bound, clk, rst_n, 1'b1, sp_reg <= SPW'(STACK_DEPTH))
    `ASSERT_NEXT(a_done_strobe, clk, rst_n, state_reg == ST_DONE, strobe_reg)
endmodule

### src/dgff_grid_mem.sv
module dgff_grid_mem #(
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [2:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [2:0]    rdata
);
    logic [2:0] mem [2**AW];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/dgff_stack_mem.sv
module dgff_stack_mem #(
    parameter int AW = 12,
    parameter int DW = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    // pending cell store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
